FILE: rtl/core/sfd_pkg.sv
// Shared types, constants and the CRC-8 byte step for the sensor frame decoder.
package sfd_pkg;

    // Frame geometry.
    localparam int FRAME_BYTES = 5;
    localparam int HELD_BYTES  = FRAME_BYTES - 1;
    localparam int POS_W       = 3;
    localparam int HELD_AW     = 2;

    // CRC-8 polynomial, MSB first, initial value zero.
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Reset value of the header register.
    localparam logic [3:0] HEADER_RESET = 4'd9;

    // Temperature offset in tenths of a degree.
    localparam logic [11:0] TEMP_OFFSET = 12'd400;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [1:0] STATUS_HDR_ERR = 2'd2;

    // One classified frame, passed from the front part to the back part.
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] b0_low;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] rx_crc;
    } frame_rec_t;

    // One CRC-8 update over a full byte, bit by bit, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] val_in);
        logic [7:0] crc;
        logic [7:0] val;
        logic       top;
        crc = crc_in;
        val = val_in;
        for (int i = 0; i < 8; i++)
        begin
            top = crc[7] ^ val[7];
            crc = {crc[6:0], 1'b0};
            if (top)
            begin
                crc = crc ^ CRC_POLY;
            end
            val = {val[6:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

FILE: rtl/core/sensor_frame_decoder_crc8.sv
// Top level of the sensor frame decoder with CRC-8 check.
//
// Usage: frame bytes arrive on the input channel (in_valid/in_ready), one byte
// per transaction, with frame_start marking byte zero of a new frame. Bytes
// zero to three are held and run through a CRC-8 (polynomial 0x31, MSB first).
// The fifth byte is compared with the CRC and the header nibble of byte zero
// with the header register, and one result transaction follows on the output
// channel (out_valid/out_ready) with a status and the decoded sensor fields.
// Throughput is one byte per cycle while the queue is not full: the CRC byte
// step is unrolled and the field decode sits in the back part behind a
// two-entry queue. A frame passes through the queue into the output register.
// When the receiver stalls, up to two classified frames wait in the queue
// besides the one in the output register; in_ready drops only when the queue
// is full. Reset clears the byte position, the CRC, the queue and the output
// valid, and loads the header register with 9. The user must write it through
// cfg_write_en/cfg_write_data only while the block is idle; the block itself
// does not enforce this.
module sensor_frame_decoder_crc8
    import sfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               frame_start,
    input  logic               cfg_write_en,
    input  logic [3:0]         cfg_write_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [5:0]         sensor_id,
    output logic               new_battery,
    output logic               flag_bit12,
    output logic signed [11:0] temperature_tenths,
    output logic               weak_battery,
    output logic [6:0]         humidity,
    output logic [7:0]         received_crc
);

    logic       q_full;
    logic       q_push;
    frame_rec_t q_rec;
    logic       q_pop;
    logic       q_head_valid;
    frame_rec_t q_head_rec;

    sfd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .frame_start    (frame_start),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_rec          (q_rec)
    );

    sfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_rec   (q_rec),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_rec   (q_head_rec)
    );

    sfd_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .head_valid         (q_head_valid),
        .head_rec           (q_head_rec),
        .pop                (q_pop),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .sensor_id          (sensor_id),
        .new_battery        (new_battery),
        .flag_bit12         (flag_bit12),
        .temperature_tenths (temperature_tenths),
        .weak_battery       (weak_battery),
        .humidity           (humidity),
        .received_crc       (received_crc)
    );

endmodule

FILE: rtl/core/sfd_front.sv
// Front part: accepts frame bytes, runs the CRC, holds bytes and classifies frames.
module sfd_front
    import sfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       data_byte,
    input  logic             frame_start,
    input  logic             cfg_write_en,
    input  logic [3:0]       cfg_write_data,
    input  logic             q_full,
    output logic             q_push,
    output frame_rec_t       q_rec
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       crc_reg;
    logic [7:0]       crc_next;
    logic [3:0]       header_reg;
    logic [7:0]       held_reg [HELD_BYTES];

    logic [POS_W-1:0] pos_eff;
    logic [7:0]       crc_eff;
    logic             accept;
    logic             last_byte;

    // A frame start restarts assembly at byte zero with a clear CRC.
    assign pos_eff   = frame_start ? '0 : pos_reg;
    assign crc_eff   = frame_start ? '0 : crc_reg;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign last_byte = (pos_eff == POS_W'(HELD_BYTES));
    assign q_push    = accept && last_byte;

    // Classify the frame on its final byte.
    always_comb
    begin
        q_rec.b0_low = held_reg[0][3:0];
        q_rec.b1     = held_reg[1];
        q_rec.b2     = held_reg[2];
        q_rec.b3     = held_reg[3];
        q_rec.rx_crc = data_byte;
        if (data_byte != crc_eff)
        begin
            q_rec.status = STATUS_CRC_ERR;
        end
        else if (held_reg[0][7:4] != header_reg)
        begin
            q_rec.status = STATUS_HDR_ERR;
        end
        else
        begin
            q_rec.status = STATUS_OK;
        end
    end

    // Position and CRC update for each accepted transaction.
    always_comb
    begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                pos_next = '0;
                crc_next = '0;
            end
            else
            begin
                pos_next = pos_eff + POS_W'(1);
                crc_next = crc8_byte(crc_eff, data_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            crc_reg    <= '0;
            header_reg <= HEADER_RESET;
        end
        else
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            if (cfg_write_en)
            begin
                header_reg <= cfg_write_data;
            end
        end
    end

    // Held frame bytes; payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (accept && !last_byte)
        begin
            held_reg[pos_eff[HELD_AW-1:0]] <= data_byte;
        end
    end

endmodule

FILE: rtl/core/sfd_queue.sv
// Short queue of classified frames between the front and back parts.
module sfd_queue
    import sfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_rec_t push_rec,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output frame_rec_t head_rec
);

    frame_rec_t          entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;
    logic                do_pop;

    assign full       = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + QUEUE_AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + QUEUE_AW'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + QUEUE_CW'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

`ifndef SYNTHESIS
    // The front never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("sfd_queue: push while full");

    // Occupancy never exceeds the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("sfd_queue: occupancy overflow");

    // A push without a pop raises the occupancy by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> (count_reg == $past(count_reg) + QUEUE_CW'(1)))
        else $error("sfd_queue: occupancy not tracking pushes");

    // Pointers agree with occupancy when the queue is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("sfd_queue: pointers out of step");
`endif

endmodule

FILE: rtl/core/sfd_back.sv
// Back part: decodes queued frames into result fields and holds the output register.
module sfd_back
    import sfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  frame_rec_t         head_rec,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [5:0]         sensor_id,
    output logic               new_battery,
    output logic               flag_bit12,
    output logic signed [11:0] temperature_tenths,
    output logic               weak_battery,
    output logic [6:0]         humidity,
    output logic [7:0]         received_crc
);

    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [5:0]         sensor_id_reg;
    logic               new_battery_reg;
    logic               flag_bit12_reg;
    logic signed [11:0] temp_reg;
    logic               weak_battery_reg;
    logic [6:0]         humidity_reg;
    logic [7:0]         received_crc_reg;

    logic               good;
    logic [11:0]        digit_sum;
    logic signed [11:0] temp_dec;

    // Load a new result when the output register is empty or being taken.
    assign pop  = head_valid && (!out_valid_reg || out_ready);
    assign good = (head_rec.status == STATUS_OK);

    // BCD digits weighted 100, 10, 1, then offset to signed tenths.
    assign digit_sum = (12'(head_rec.b1[3:0]) * 12'd100)
                     + (12'(head_rec.b2[7:4]) * 12'd10)
                     + 12'(head_rec.b2[3:0]);
    assign temp_dec  = $signed(digit_sum - TEMP_OFFSET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; decoded fields are zero for a failed frame.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg       <= head_rec.status;
            received_crc_reg <= head_rec.rx_crc;
            sensor_id_reg    <= good ? {head_rec.b0_low, head_rec.b1[7:6]} : '0;
            new_battery_reg  <= good & head_rec.b1[5];
            flag_bit12_reg   <= good & head_rec.b1[4];
            temp_reg         <= good ? temp_dec : '0;
            weak_battery_reg <= good & head_rec.b3[7];
            humidity_reg     <= good ? head_rec.b3[6:0] : '0;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign sensor_id          = sensor_id_reg;
    assign new_battery        = new_battery_reg;
    assign flag_bit12         = flag_bit12_reg;
    assign temperature_tenths = temp_reg;
    assign weak_battery       = weak_battery_reg;
    assign humidity           = humidity_reg;
    assign received_crc       = received_crc_reg;

endmodule

FILE: test/sfd_tb_pkg.sv
`timescale 1ns / 1ps
// Shared reading type and CRC-8 helper for the sensor frame decoder testbench.
package sfd_tb_pkg;

    // One decoded sensor reading as it leaves the block.
    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         sensor_id;
        logic               new_battery;
        logic               flag_bit12;
        logic signed [11:0] temperature_tenths;
        logic               weak_battery;
        logic [6:0]         humidity;
        logic [7:0]         received_crc;
    } reading_t;

    // CRC-8 over one byte, MSB first: fold the byte in, then shift eight times.
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        acc = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (acc[7])
            begin
                acc = {acc[6:0], 1'b0} ^ sfd_pkg::CRC_POLY;
            end
            else
            begin
                acc = {acc[6:0], 1'b0};
            end
        end
        return acc;
    endfunction

endpackage

FILE: test/sfd_reading_checker.sv
`timescale 1ns / 1ps
// Checker that predicts decoded sensor readings and compares them with the block's output.
module sfd_reading_checker
    import sfd_pkg::*;
    import sfd_tb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               frame_start,
    input  logic               cfg_write_en,
    input  logic [3:0]         cfg_write_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         status,
    input  logic [5:0]         sensor_id,
    input  logic               new_battery,
    input  logic               flag_bit12,
    input  logic signed [11:0] temperature_tenths,
    input  logic               weak_battery,
    input  logic [6:0]         humidity,
    input  logic [7:0]         received_crc,
    output int                 mismatch_count,
    output int                 expected_left
);

    // Shadow copy of the frame assembly state and the header register.
    logic [POS_W-1:0] frame_pos;
    logic [7:0]       frame_crc;
    logic [7:0]       frame_bytes [HELD_BYTES];
    logic [3:0]       header_reg;
    reading_t         expected_readings [$];

    initial
    begin
        mismatch_count = 0;
        expected_left  = 0;
    end

    // Prints one line per bad reading and counts it.
    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Works out the reading that the fifth byte of a frame produces.
    function automatic reading_t decode_reading(input logic [7:0] crc_byte);
        reading_t r;
        int       tenths;
        r = '0;
        r.received_crc = crc_byte;
        if (crc_byte != frame_crc)
        begin
            r.status = STATUS_CRC_ERR;
        end
        else if (frame_bytes[0][7:4] != header_reg)
        begin
            r.status = STATUS_HDR_ERR;
        end
        else
        begin
            r.status       = STATUS_OK;
            r.sensor_id    = {frame_bytes[0][3:0], frame_bytes[1][7:6]};
            r.new_battery  = frame_bytes[1][5];
            r.flag_bit12   = frame_bytes[1][4];
            tenths = 100 * int'(frame_bytes[1][3:0]) + 10 * int'(frame_bytes[2][7:4])
                   + int'(frame_bytes[2][3:0]) - 400;
            r.temperature_tenths = tenths[11:0];
            r.weak_battery = frame_bytes[3][7];
            r.humidity     = frame_bytes[3][6:0];
        end
        return r;
    endfunction

    // Track the channels at each edge: results first, then input bytes, then config.
    always @(posedge clk or negedge rst_n)
    begin
        reading_t got;
        reading_t exp;
        if (!rst_n)
        begin
            frame_pos  = '0;
            frame_crc  = '0;
            header_reg = HEADER_RESET;
            expected_readings.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{status, sensor_id, new_battery, flag_bit12, temperature_tenths,
                        weak_battery, humidity, received_crc};
                if (expected_readings.size() == 0)
                begin
                    report_mismatch($sformatf("reading with none expected: %p", got));
                end
                else
                begin
                    exp = expected_readings.pop_front();
                    if (got.status != exp.status || got.sensor_id != exp.sensor_id
                        || got.new_battery != exp.new_battery
                        || got.flag_bit12 != exp.flag_bit12
                        || got.temperature_tenths != exp.temperature_tenths
                        || got.weak_battery != exp.weak_battery
                        || got.humidity != exp.humidity
                        || got.received_crc != exp.received_crc)
                    begin
                        report_mismatch($sformatf("got %p, expected %p", got, exp));
                    end
                end
            end

            // Byte transaction: restart on frame start, hold four bytes, decode on the fifth.
            if (in_valid && in_ready)
            begin
                if (frame_start)
                begin
                    frame_pos = '0;
                    frame_crc = '0;
                end
                if (frame_pos < POS_W'(HELD_BYTES))
                begin
                    frame_bytes[frame_pos[HELD_AW-1:0]] = data_byte;
                    frame_crc = crc8_next(frame_crc, data_byte);
                    frame_pos = frame_pos + 1'b1;
                end
                else
                begin
                    expected_readings.push_back(decode_reading(data_byte));
                    frame_pos = '0;
                    frame_crc = '0;
                end
            end

            // The header register takes its new value after this edge's classification.
            if (cfg_write_en)
            begin
                header_reg = cfg_write_data;
            end
        end
        expected_left = expected_readings.size();
    end

endmodule

FILE: test/tb_sensor_frame_decoder_crc8.sv
`timescale 1ns / 1ps
// Top of the sensor frame decoder testbench: clock, reset, stimulus and verdict.
module tb_sensor_frame_decoder_crc8;
    import sfd_pkg::*;
    import sfd_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 6;
    localparam int PHASE_BYTES  = 135;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         data_byte;
    logic               frame_start;
    logic               cfg_write_en;
    logic [3:0]         cfg_write_data;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic [5:0]         sensor_id;
    logic               new_battery;
    logic               flag_bit12;
    logic signed [11:0] temperature_tenths;
    logic               weak_battery;
    logic [6:0]         humidity;
    logic [7:0]         received_crc;

    int                 mismatch_count;
    int                 expected_left;
    int                 cycle_count;
    int                 bytes_sent;
    bit                 no_idle;
    logic [3:0]         cur_header;

    sensor_frame_decoder_crc8 DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .data_byte          (data_byte),
        .frame_start        (frame_start),
        .cfg_write_en       (cfg_write_en),
        .cfg_write_data     (cfg_write_data),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .sensor_id          (sensor_id),
        .new_battery        (new_battery),
        .flag_bit12         (flag_bit12),
        .temperature_tenths (temperature_tenths),
        .weak_battery       (weak_battery),
        .humidity           (humidity),
        .received_crc       (received_crc)
    );

    sfd_reading_checker checker_inst (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .data_byte          (data_byte),
        .frame_start        (frame_start),
        .cfg_write_en       (cfg_write_en),
        .cfg_write_data     (cfg_write_data),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .sensor_id          (sensor_id),
        .new_battery        (new_battery),
        .flag_bit12         (flag_bit12),
        .temperature_tenths (temperature_tenths),
        .weak_battery       (weak_battery),
        .humidity           (humidity),
        .received_crc       (received_crc),
        .mismatch_count     (mismatch_count),
        .expected_left      (expected_left)
    );

    // Clock with a 20 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Receiver stalls about 7 percent of the time, except in the quiet phase.
    always @(posedge clk)
    begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 7);
    end

    // Hard limit on run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // One byte transaction, with a random one-cycle idle gap in front of it.
    task automatic send_byte(input logic [7:0] b, input logic start);
        if (!no_idle && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        frame_start <= start;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // Sends the first n_bytes of a frame; the fifth byte is the CRC, correct or corrupted.
    task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3,
                              input bit crc_ok, input logic lead_start, input int n_bytes);
        logic [7:0] fb [4];
        logic [7:0] crc;
        fb  = '{b0, b1, b2, b3};
        crc = '0;
        for (int i = 0; i < 4; i++)
        begin
            crc = crc8_next(crc, fb[i]);
        end
        for (int i = 0; i < 4 && i < n_bytes; i++)
        begin
            send_byte(fb[i], (i == 0) ? lead_start : 1'b0);
        end
        if (n_bytes > 4)
        begin
            send_byte(crc_ok ? crc : crc ^ (8'h01 << $urandom_range(0, 7)), 1'b0);
        end
    endtask

    // Holds the sender off until every reading has come out, then lets the block settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_left != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Header register write; only called while the block is idle.
    task automatic write_header(input logic [3:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        cur_header = value;
    endtask

    initial
    begin
        int         pick;
        int         phase_start;
        logic [7:0] b0;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = '0;
        frame_start    = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        out_ready      = 1'b0;
        cycle_count    = 0;
        bytes_sent     = 0;
        no_idle        = 1'b0;
        cur_header     = HEADER_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under the reset header value.
        // Largest fields, including out-of-range BCD digits.
        send_frame(8'h9F, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 5);
        // Smallest fields; the first byte has no start flag but follows a finished frame.
        send_frame(8'h90, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 5);
        // Bad CRC together with a bad header: CRC error wins.
        send_frame(8'h3A, 8'h5C, 8'h12, 8'h80, 1'b0, 1'b1, 5);
        // Good CRC, wrong header.
        send_frame(8'h6B, 8'hA7, 8'h45, 8'h33, 1'b1, 1'b1, 5);
        // Frame start in the middle of a frame drops the partial frame.
        send_byte(8'h9C, 1'b1);
        send_byte(8'h11, 1'b0);
        send_frame(8'h95, 8'h6A, 8'h99, 8'h48, 1'b1, 1'b1, 5);
        wait_drained();

        // Random phases, each under its own header setting.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: write_header(4'h0);
                1: write_header(4'hF);
                3: write_header(HEADER_RESET);
                default: write_header(4'($urandom));
            endcase
            no_idle     = (ph == 3);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                pick = $urandom_range(0, 99);
                b0   = {($urandom_range(0, 99) < 80) ? cur_header : 4'($urandom),
                        4'($urandom)};
                if (pick < 75)
                begin
                    send_frame(b0, 8'($urandom), 8'($urandom), 8'($urandom),
                               $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 90, 5);
                end
                else if (pick < 87)
                begin
                    send_frame(b0, 8'($urandom), 8'($urandom), 8'($urandom),
                               1'b1, 1'b1, $urandom_range(1, 4));
                end
                else
                begin
                    send_byte(8'($urandom), 1'($urandom_range(0, 1)));
                end
            end
            no_idle = 1'b0;
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_left == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
